// ===== src/hdg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_pkg: shared types, constants and tables for the vector heading block
// Holds the coordinate width, the pipeline item record, the heading codes and
// the Q2.62 sine / cosine tables that the angle search compares against.
// ----------------------------------------------------------------------------
package hdg_pkg;

  // coordinate width of one vector component
  localparam int COORD_BITS = 16;
  // magnitude of a component fits the same width (most negative included)
  localparam int MAG_W      = COORD_BITS;

  // truncated angle in degrees, 0..T_MAX
  localparam int T_MAX      = 44;
  localparam int TW         = $clog2(T_MAX + 1);
  localparam int NUM_STEPS  = TW;
  localparam int TAB_N      = 2 ** TW;
  localparam int TAB_LAST   = 45;

  // partial products and differences in the angle compare
  localparam int HALF_W     = 32;
  localparam int PROD_W     = MAG_W + HALF_W;
  localparam int DIFF_W     = PROD_W + 1;
  localparam int SUM_W      = DIFF_W + 1;

  localparam int DEG_W      = 9;

  // heading codes in degrees
  localparam logic [DEG_W-1:0] DEG_0   = DEG_W'(0);
  localparam logic [DEG_W-1:0] DEG_45  = DEG_W'(45);
  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_135 = DEG_W'(135);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_225 = DEG_W'(225);
  localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
  localparam logic [DEG_W-1:0] DEG_315 = DEG_W'(315);
  localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);

  // fixed point constants, value * 2^62
  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

  typedef logic [TAB_N-1:0][63:0] tab_t;

  // one vector as it travels down the pipeline
  typedef struct packed {
    logic [MAG_W-1:0] minor;
    logic [MAG_W-1:0] major;
    logic [TW-1:0]    t;
    logic [TW-1:0]    probe;
    logic [DEG_W-1:0] base;
    logic             sub;
    logic             use_t;
    logic             has;
  } item_t;

  // q2.62 product, truncated
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // taylor series tables for 0..45 degrees, evaluated at elaboration
  function automatic tab_t gen_tab(input logic want_cos);
    tab_t        r;
    logic [63:0] one_deg;
    logic [63:0] x;
    logic [63:0] st;
    logic [63:0] ss;
    logic [63:0] ct;
    logic [63:0] cs;
    r = '0;
    one_deg = PI_Q62 / 64'd180;
    for (int k = 0; k <= TAB_LAST; k++) begin
      x  = one_deg * 64'(k);
      st = x;
      ss = x;
      ct = Q62_ONE;
      cs = Q62_ONE;
      for (int n = 1; n <= 13; n++) begin
        st = mul_q62(mul_q62(st, x), x) / 64'((2 * n) * (2 * n + 1));
        ct = mul_q62(mul_q62(ct, x), x) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      r[k] = want_cos ? cs : ss;
    end
    return r;
  endfunction

  localparam tab_t SIN_TAB = gen_tab(1'b0);
  localparam tab_t COS_TAB = gen_tab(1'b1);

endpackage
`default_nettype wire

// ===== src/hdg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_front: input stage of the heading pipeline
// Takes component magnitudes, picks the dominant axis, settles the special
// headings and the quadrant base, and registers the item for the search.
// ----------------------------------------------------------------------------
module hdg_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              in_valid_i,
  input  wire logic signed [hdg_pkg::MAG_W-1:0]  delta_x_i,
  input  wire logic signed [hdg_pkg::MAG_W-1:0]  delta_y_i,
  output logic                                   valid_o,
  output hdg_pkg::item_t                         item_o
);

  logic                        xneg;
  logic                        yneg;
  logic [hdg_pkg::MAG_W-1:0]   ax;
  logic [hdg_pkg::MAG_W-1:0]   ay;
  logic                        x_major;
  hdg_pkg::item_t              item_d;
  logic                        valid_q;
  hdg_pkg::item_t              item_q;

  // magnitudes, most negative value maps to 2^(w-1)
  assign xneg = delta_x_i[hdg_pkg::MAG_W-1];
  assign yneg = delta_y_i[hdg_pkg::MAG_W-1];
  assign ax   = xneg ? (~delta_x_i + 1'b1) : delta_x_i;
  assign ay   = yneg ? (~delta_y_i + 1'b1) : delta_y_i;
  assign x_major = (ax >= ay);

  // classify: fixed heading, or quadrant base plus or minus the angle
  always_comb begin
    item_d       = '0;
    item_d.minor = x_major ? ay : ax;
    item_d.major = x_major ? ax : ay;
    item_d.t     = '0;
    item_d.probe = hdg_pkg::TW'(1) << (hdg_pkg::TW - 1);
    item_d.has   = (ax != '0) || (ay != '0);
    item_d.use_t = 1'b0;
    item_d.sub   = 1'b0;
    item_d.base  = hdg_pkg::DEG_0;
    if (!item_d.has) begin
      item_d.base = hdg_pkg::DEG_0;
    end else if (x_major) begin
      if (ay == '0) begin
        item_d.base = xneg ? hdg_pkg::DEG_180 : hdg_pkg::DEG_0;
      end else if (ax == ay) begin
        if (!xneg) begin
          item_d.base = yneg ? hdg_pkg::DEG_45 : hdg_pkg::DEG_315;
        end else begin
          item_d.base = yneg ? hdg_pkg::DEG_135 : hdg_pkg::DEG_225;
        end
      end else begin
        item_d.use_t = 1'b1;
        if (!xneg) begin
          item_d.base = yneg ? hdg_pkg::DEG_0 : hdg_pkg::DEG_360;
          item_d.sub  = !yneg;
        end else begin
          item_d.base = hdg_pkg::DEG_180;
          item_d.sub  = yneg;
        end
      end
    end else begin
      if (ax == '0) begin
        item_d.base = yneg ? hdg_pkg::DEG_90 : hdg_pkg::DEG_270;
      end else begin
        item_d.use_t = 1'b1;
        item_d.base  = yneg ? hdg_pkg::DEG_90 : hdg_pkg::DEG_270;
        item_d.sub   = yneg ? !xneg : xneg;
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== src/hdg_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_step: one bit of the angle search
// Probes candidate t|probe with minor*cos(k) >= major*sin(k) on the Q2.62
// tables, in three register stages: partial products, half differences and
// the sign of the full difference with the update of t.
// ----------------------------------------------------------------------------
module hdg_step (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire hdg_pkg::item_t item_i,
  output logic         valid_o,
  output hdg_pkg::item_t item_o
);

  logic [hdg_pkg::TW-1:0]                cand;
  logic                                  cand_ok;
  logic [63:0]                           cos_k;
  logic [63:0]                           sin_k;

  logic                                  a_valid_q;
  hdg_pkg::item_t                        a_item_q;
  logic [hdg_pkg::TW-1:0]                a_cand_q;
  logic                                  a_ok_q;
  logic [hdg_pkg::PROD_W-1:0]            mc_lo_q;
  logic [hdg_pkg::PROD_W-1:0]            mc_hi_q;
  logic [hdg_pkg::PROD_W-1:0]            ms_lo_q;
  logic [hdg_pkg::PROD_W-1:0]            ms_hi_q;

  logic                                  b_valid_q;
  hdg_pkg::item_t                        b_item_q;
  logic [hdg_pkg::TW-1:0]                b_cand_q;
  logic                                  b_ok_q;
  logic signed [hdg_pkg::DIFF_W-1:0]     lo_diff_d;
  logic signed [hdg_pkg::DIFF_W-1:0]     hi_diff_d;
  logic signed [hdg_pkg::DIFF_W-1:0]     lo_diff_q;
  logic signed [hdg_pkg::DIFF_W-1:0]     hi_diff_q;

  logic signed [hdg_pkg::DIFF_W-1:0]     lo_top;
  logic signed [hdg_pkg::SUM_W-1:0]      sum;
  logic                                  pass;
  hdg_pkg::item_t                        c_item_d;
  logic                                  c_valid_q;
  hdg_pkg::item_t                        c_item_q;

  // candidate angle and its table entries
  assign cand    = item_i.t | item_i.probe;
  assign cand_ok = (cand <= hdg_pkg::TW'(hdg_pkg::T_MAX));
  assign cos_k   = hdg_pkg::COS_TAB[cand];
  assign sin_k   = hdg_pkg::SIN_TAB[cand];

  // half differences of the products, low and high table words
  assign lo_diff_d = $signed({1'b0, mc_lo_q}) - $signed({1'b0, ms_lo_q});
  assign hi_diff_d = $signed({1'b0, mc_hi_q}) - $signed({1'b0, ms_hi_q});

  // sign of hi*2^32 + lo equals sign of hi + floor(lo / 2^32)
  assign lo_top = lo_diff_q >>> hdg_pkg::HALF_W;
  assign sum    = $signed({hi_diff_q[hdg_pkg::DIFF_W-1], hi_diff_q})
                + $signed({lo_top[hdg_pkg::DIFF_W-1], lo_top});
  assign pass   = b_ok_q && !sum[hdg_pkg::SUM_W-1];

  // keep the candidate when it holds, move on to the next bit
  always_comb begin
    c_item_d       = b_item_q;
    c_item_d.t     = pass ? b_cand_q : b_item_q.t;
    c_item_d.probe = b_item_q.probe >> 1;
  end

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // payload of the three stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q  <= item_i;
      a_cand_q  <= cand;
      a_ok_q    <= cand_ok;
      mc_lo_q   <= hdg_pkg::PROD_W'(item_i.minor) * hdg_pkg::PROD_W'(cos_k[31:0]);
      mc_hi_q   <= hdg_pkg::PROD_W'(item_i.minor) * hdg_pkg::PROD_W'(cos_k[63:32]);
      ms_lo_q   <= hdg_pkg::PROD_W'(item_i.major) * hdg_pkg::PROD_W'(sin_k[31:0]);
      ms_hi_q   <= hdg_pkg::PROD_W'(item_i.major) * hdg_pkg::PROD_W'(sin_k[63:32]);
      b_item_q  <= a_item_q;
      b_cand_q  <= a_cand_q;
      b_ok_q    <= a_ok_q;
      lo_diff_q <= lo_diff_d;
      hi_diff_q <= hi_diff_d;
      c_item_q  <= c_item_d;
    end
  end

  assign valid_o = c_valid_q;
  assign item_o  = c_item_q;

endmodule
`default_nettype wire

// ===== src/hdg_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_map: quadrant mapping and output register
// Adds or subtracts the searched angle from the quadrant base, wraps a full
// turn to zero and holds the result until the transaction completes.
// ----------------------------------------------------------------------------
module hdg_map (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire hdg_pkg::item_t              item_i,
  output logic                             out_valid_o,
  output logic [hdg_pkg::DEG_W-1:0]        heading_deg_o,
  output logic                             has_heading_o
);

  logic [hdg_pkg::DEG_W-1:0] t_ext;
  logic [hdg_pkg::DEG_W-1:0] raw;
  logic [hdg_pkg::DEG_W-1:0] deg_d;
  logic                      out_valid_q;
  logic [hdg_pkg::DEG_W-1:0] deg_q;
  logic                      has_q;

  // base plus or minus t, full turn wraps to zero
  assign t_ext = hdg_pkg::DEG_W'(item_i.t);
  always_comb begin
    if (!item_i.use_t) begin
      raw = item_i.base;
    end else if (item_i.sub) begin
      raw = item_i.base - t_ext;
    end else begin
      raw = item_i.base + t_ext;
    end
    deg_d = (raw == hdg_pkg::DEG_360) ? hdg_pkg::DEG_0 : raw;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q <= deg_d;
      has_q <= item_i.has;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign heading_deg_o = deg_q;
  assign has_heading_o = has_q;

endmodule
`default_nettype wire

// ===== src/vector_heading_degrees_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_heading_degrees_top: heading of a screen-space vector in degrees
// Input channel (in_valid_i / in_ready_o) carries delta_x_i and delta_y_i,
// signed, screen y growing downward. Output channel (out_valid_o /
// out_ready_i) carries heading_deg_o in 0..359 and has_heading_o, which is
// low, with a heading of zero, for the zero vector.
// An input transaction passes through one input stage, six search steps of
// three stages each (one bit of the truncated angle per step, products
// against the sine / cosine tables) and the output register on its way to
// its result. Throughput is one transaction per cycle unless stalled.
// When the receiver stalls with a result pending, the whole pipeline holds
// and in_ready_o drops; nothing is dropped or repeated, and in_ready_o is
// high whenever the output register is empty or being taken.
// Reset clears every valid bit; the pipeline is empty right after reset.
// ----------------------------------------------------------------------------
module vector_heading_degrees_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [hdg_pkg::MAG_W-1:0]   delta_x_i,
  input  wire logic signed [hdg_pkg::MAG_W-1:0]   delta_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [hdg_pkg::DEG_W-1:0]               heading_deg_o,
  output logic                                    has_heading_o
);

  logic                          en;
  logic [hdg_pkg::NUM_STEPS:0]   stg_valid;
  hdg_pkg::item_t                stg_item [hdg_pkg::NUM_STEPS+1];

  // whole pipeline advances unless a result waits on the receiver
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // input stage
  hdg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .delta_x_i  (delta_x_i),
    .delta_y_i  (delta_y_i),
    .valid_o    (stg_valid[0]),
    .item_o     (stg_item[0])
  );

  // angle search, most significant bit first
  for (genvar i = 0; i < hdg_pkg::NUM_STEPS; i++) begin : g_step
    hdg_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stg_valid[i]),
      .item_i  (stg_item[i]),
      .valid_o (stg_valid[i+1]),
      .item_o  (stg_item[i+1])
    );
  end

  // quadrant mapping and output register
  hdg_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (stg_valid[hdg_pkg::NUM_STEPS]),
    .item_i        (stg_item[hdg_pkg::NUM_STEPS]),
    .out_valid_o   (out_valid_o),
    .heading_deg_o (heading_deg_o),
    .has_heading_o (has_heading_o)
  );

endmodule
`default_nettype wire
